/* sv/b64d_pkg.sv */
package b64d_pkg;

    // Width of the running byte total; it saturates at its all-ones value.
    localparam int COUNT_WIDTH = 16;
    // Width of the count carried in a summary word.
    localparam int SUMMARY_WIDTH = 16;
    // Group queue between the decoder and the result port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CAP_RESET = 8'd64;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_PAD  = 8'h3D;   // '='
    localparam logic [7:0] CHAR_PLUS = 8'h2B;   // '+'
    localparam logic [7:0] CHAR_SLSH = 8'h2F;   // '/'
    localparam logic [7:0] CHAR_UA   = 8'h41;   // 'A'
    localparam logic [7:0] CHAR_UZ   = 8'h5A;   // 'Z'
    localparam logic [7:0] CHAR_LA   = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_LZ   = 8'h7A;   // 'z'
    localparam logic [7:0] CHAR_D0   = 8'h30;   // '0'
    localparam logic [7:0] CHAR_D9   = 8'h39;   // '9'

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // All results caused by one input character: data bytes first, then
    // an optional summary.
    typedef struct packed {
        logic [1:0]               n_bytes;
        byte_t [2:0]              bytes;
        logic                     has_summary;
        logic [SUMMARY_WIDTH-1:0] count;
        logic                     bad;
    } b64d_group_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        logic [7:0] d;
        s.valid = 1'b1;
        s.value = 6'd0;
        d       = 8'd0;
        if (c >= CHAR_UA && c <= CHAR_UZ) begin
            d = c - CHAR_UA;
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ) begin
            d = c - CHAR_LA + 8'd26;
        end
        else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            d = c - CHAR_D0 + 8'd52;
        end
        else if (c == CHAR_PLUS) begin
            d = 8'd62;
        end
        else if (c == CHAR_SLSH) begin
            d = 8'd63;
        end
        else begin
            s.valid = 1'b0;
        end
        s.value = d[5:0];
        return s;
    endfunction

endpackage

/* sv/b64d_char_if.sv */
interface b64d_char_if;
    import b64d_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

/* sv/b64d_result_if.sv */
interface b64d_result_if;
    import b64d_pkg::*;

    logic                     valid;
    logic                     ready;
    byte_t                    out_byte;
    logic                     is_summary;
    logic [SUMMARY_WIDTH-1:0] decoded_count;
    logic                     bad_input;
    logic                     out_last;

    modport source (output valid, output out_byte, output is_summary,
                    output decoded_count, output bad_input, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_summary,
                    input decoded_count, input bad_input, input out_last,
                    output ready);
endinterface

/* sv/b64d_cfg_if.sv */
interface b64d_cfg_if;
    import b64d_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

/* sv/base64_stream_decoder.sv */
// Streaming base64 decoder. One character word enters per cycle on chars
// whenever ready is high; ready drops only while the four-group result queue
// is full. Characters outside A-Z a-z 0-9 + / = and NUL are skipped. Every
// fourth valid character yields up to three data words, as capacity allows;
// '=' flushes up to two bytes and a summary word, NUL clears the stream and
// gives a summary word unless a pad already ended it. The decoder state
// updates in the cycle of acceptance and the results of that character land
// as one group in the queue, so nothing waits on the result side. The results
// port drains one word per cycle while its ready is high, so the sustained
// rate is one character per cycle as long as the stream averages at most one
// result per character (four characters to three bytes). out_capacity is taken
// on cfg at any time and applies to later bytes at once; its reset value is 64.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    b64d_cfg_if.sink       cfg,
    b64d_char_if.sink      chars,
    b64d_result_if.source  results
);

    logic        queue_full;
    logic        accept;
    logic        group_valid;
    b64d_group_t group;

    // take a character whenever the queue can hold its group
    assign chars.ready = !queue_full;
    assign accept      = chars.valid && chars.ready;

    b64d_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .in_char     (chars.in_char),
        .group_valid (group_valid),
        .group       (group)
    );

    // characters that cause no result are not queued
    b64d_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (group_valid),
        .push_group (group),
        .full       (queue_full),
        .res        (results)
    );

endmodule

/* sv/b64d_decode.sv */
module b64d_decode
    import b64d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    b64d_cfg_if.sink       cfg,
    input  logic           accept,
    input  byte_t          in_char,
    output logic           group_valid,
    output b64d_group_t    group
);

    byte_t                  cap_reg;
    logic [17:0]            acc_reg,     acc_next;
    logic [1:0]             pend_reg,    pend_next;
    logic [COUNT_WIDTH-1:0] total_reg,   total_next;
    byte_t                  emitted_reg, emitted_next;
    logic                   stopped_reg, stopped_next;

    sextet_t                sx;
    byte_t [2:0]            cand;
    logic [1:0]             n_cand;
    logic                   do_summary;
    logic                   bad;
    logic                   do_clear;
    logic [2:0]             pass;
    logic [1:0]             n_emit;
    logic [COUNT_WIDTH:0]   total_sum;
    logic [COUNT_WIDTH-1:0] total_sat;
    logic [31:0]            total_wide;
    logic [SUMMARY_WIDTH-1:0] sum_count;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        sx         = sextet_of(in_char);
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        stopped_next = stopped_reg;
        cand       = '0;
        n_cand     = 2'd0;
        do_summary = 1'b0;
        bad        = 1'b0;
        do_clear   = 1'b0;

        if (accept) begin
            if (stopped_reg) begin
                // after pad: wait for NUL, drop everything else
                do_clear = (in_char == CHAR_NUL);
            end
            else if (in_char == CHAR_NUL) begin
                do_summary = 1'b1;
                bad        = (pend_reg != 2'd0);
                do_clear   = 1'b1;
            end
            else if (in_char == CHAR_PAD) begin
                unique case (pend_reg)
                    2'd0: ;
                    2'd1: bad = 1'b1;
                    2'd2:
                    begin
                        cand[0] = acc_reg[11:4];
                        n_cand  = 2'd1;
                    end
                    2'd3:
                    begin
                        cand[0] = acc_reg[17:10];
                        cand[1] = acc_reg[9:2];
                        n_cand  = 2'd2;
                    end
                endcase
                do_summary   = 1'b1;
                acc_next     = '0;
                pend_next    = 2'd0;
                stopped_next = 1'b1;
            end
            else if (sx.valid) begin
                if (pend_reg == 2'd3) begin
                    cand[0]   = acc_reg[17:10];
                    cand[1]   = acc_reg[9:2];
                    cand[2]   = {acc_reg[1:0], sx.value};
                    n_cand    = 2'd3;
                    acc_next  = '0;
                    pend_next = 2'd0;
                end
                else begin
                    acc_next  = {acc_reg[11:0], sx.value};
                    pend_next = pend_reg + 2'd1;
                end
            end
        end

        // a byte goes out only while emitted + 1 stays below capacity
        for (int j = 0; j < 3; j++) begin
            pass[j] = (2'(j) < n_cand) &&
                      ((10'(emitted_reg) + 10'(j) + 10'd1) < 10'(cap_reg));
        end
        n_emit = 2'(pass[0]) + 2'(pass[1]) + 2'(pass[2]);

        total_sum = {1'b0, total_reg} + (COUNT_WIDTH+1)'(n_cand);
        total_sat = total_sum[COUNT_WIDTH] ? '1 : total_sum[COUNT_WIDTH-1:0];

        total_wide = 32'(total_sat);
        if (bad || cap_reg == 8'd0) begin
            sum_count = '0;
        end
        else if (total_wide > 32'(2**SUMMARY_WIDTH - 1)) begin
            sum_count = '1;
        end
        else begin
            sum_count = total_wide[SUMMARY_WIDTH-1:0];
        end

        emitted_next = emitted_reg + 8'(n_emit);
        total_next   = total_sat;
        if (do_clear) begin
            acc_next     = '0;
            pend_next    = 2'd0;
            total_next   = '0;
            emitted_next = '0;
            stopped_next = 1'b0;
        end

        group.n_bytes     = n_emit;
        group.bytes       = cand;
        group.has_summary = do_summary;
        group.count       = sum_count;
        group.bad         = bad;
        group_valid       = (n_emit != 2'd0) || do_summary;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg     <= CAP_RESET;
            acc_reg     <= '0;
            pend_reg    <= 2'd0;
            total_reg   <= '0;
            emitted_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                cap_reg <= cfg.out_capacity;
            end
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* sv/b64d_out_queue.sv */
module b64d_out_queue
    import b64d_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_group_t    push_group,
    output logic           full,
    b64d_result_if.source  res
);

    b64d_group_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]       fill_reg;
    logic [1:0]              idx_reg;

    b64d_group_t             head;
    logic [1:0]              n_results;
    logic                    is_last;
    logic                    pop;

    assign full      = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];
    assign n_results = head.n_bytes + 2'(head.has_summary);
    assign is_last   = (idx_reg == n_results - 2'd1);
    assign pop       = res.valid && res.ready && is_last;

    assign res.valid         = (fill_reg != '0);
    assign res.is_summary    = (idx_reg >= head.n_bytes);
    assign res.out_byte      = res.is_summary ? 8'd0 : head.bytes[idx_reg];
    assign res.decoded_count = res.is_summary ? head.count : '0;
    assign res.bad_input     = res.is_summary ? head.bad : 1'b0;
    assign res.out_last      = is_last;

    // group storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (res.valid && res.ready) begin
                // advance within the head group, drop it after its last word
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

endmodule
